// ===== hdl/gtce_pkg.sv =====
`default_nettype none

package gtce_pkg;

	// Fixed field widths of the ports
	localparam int NODE_IN_W = 4;
	localparam int COST_IN_W = 16;
	localparam int MASK_W    = 16;
	localparam int CFG_W     = 5;
	localparam int SUM_W     = 20;
	localparam int ADDED_W   = 5;

	localparam logic [CFG_W-1:0]   NODE_COUNT_RST = 5'd16;
	localparam logic [SUM_W-1:0]   SUM_MAX        = 20'hFFFFF;
	localparam logic [ADDED_W-1:0] ADDED_MAX      = 5'd31;

	// Opcodes of an input beat
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic tbl_wr;     // write one cost entry
		logic load;       // start a query walk
		logic scan_rd;    // read the candidate at the scan index
		logic take_best;  // move to the best candidate of this round
		logic ret_rd;     // read the cost back to node zero
		logic ret_add;    // add the return leg
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;  // scan index at last node in use
		logic found;      // an unvisited candidate was seen this round
		logic pos_zero;   // walk stands at node zero
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/greedy_tour_cost_estimator_unit.sv =====
// Table write (op 0): accepted while idle, busy stays low, no result beat.
// Query (op 1): busy while the walk appends k nodes, N nodes in use, then adds the
// return leg back to node zero, which is skipped when the walk already ends at node zero.
// Each round scans all N entries of the current row through one RAM read port.
// One query at a time; result_valid pulses in the last busy cycle, receiver cannot stall.
// arst_n clears the controller and sets node_count to 16; the cost table is not cleared.
`default_nettype none

module greedy_tour_cost_estimator_unit
	import gtce_pkg::*;
#(
	parameter int MAX_NODES = 16,
	parameter int COST_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 op,
	input  wire logic [NODE_IN_W-1:0] from_node,
	input  wire logic [NODE_IN_W-1:0] to_node,
	input  wire logic [COST_IN_W-1:0] edge_cost,
	input  wire logic [NODE_IN_W-1:0] current_node,
	input  wire logic [MASK_W-1:0]    visited_mask,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output logic                      result_valid,
	output logic      [SUM_W-1:0]     heuristic_cost,
	output logic      [ADDED_W-1:0]   nodes_added
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	gtce_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	gtce_dpath #(
		.MAX_NODES (MAX_NODES),
		.COST_BITS (COST_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.from_node      (from_node),
		.to_node        (to_node),
		.edge_cost      (edge_cost),
		.current_node   (current_node),
		.visited_mask   (visited_mask),
		.heuristic_cost (heuristic_cost),
		.nodes_added    (nodes_added)
	);

endmodule

`default_nettype wire

// ===== hdl/gtce_ram.sv =====
`default_nettype none

module gtce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/gtce_ctrl.sv =====
`default_nettype none

module gtce_ctrl
	import gtce_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic op,
	input  wire dp_sts_t sts,
	output dp_cmd_t   cmd,
	output logic      busy,
	output logic      result_valid
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SCAN    = 7'b0000010,
		S_WAIT    = 7'b0000100,
		S_DECIDE  = 7'b0001000,
		S_RET_RD  = 7'b0010000,
		S_RET_ADD = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start && op == OP_QUERY) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end else if (start && op == OP_WRITE) begin
					cmd.tbl_wr = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_WAIT;
				end
			end
			// last read of the round lands in the compare stage
			S_WAIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.found) begin
					cmd.take_best = 1'b1;
					state_d       = S_SCAN;
				end else if (sts.pos_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RET_RD;
				end
			end
			S_RET_RD: begin
				cmd.ret_rd = 1'b1;
				state_d    = S_RET_ADD;
			end
			S_RET_ADD: begin
				cmd.ret_add = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_DONE);

`ifndef SYNTHESIS
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_QUERY) |=> busy)
		else $error("query accepted but block not busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("block still busy after result beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/gtce_dpath.sv =====
`default_nettype none

module gtce_dpath
	import gtce_pkg::*;
#(
	parameter int MAX_NODES = 16,
	parameter int COST_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic [NODE_IN_W-1:0] from_node,
	input  wire logic [NODE_IN_W-1:0] to_node,
	input  wire logic [COST_IN_W-1:0] edge_cost,
	input  wire logic [NODE_IN_W-1:0] current_node,
	input  wire logic [MASK_W-1:0]    visited_mask,
	output logic      [SUM_W-1:0]     heuristic_cost,
	output logic      [ADDED_W-1:0]   nodes_added
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int DEPTH  = MAX_NODES * MAX_NODES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MX_W   = (MAX_NODES > MASK_W) ? MAX_NODES : MASK_W;
	localparam int ADD_W  = ((COST_BITS > SUM_W) ? COST_BITS : SUM_W) + 1;

	// current_node modulo MAX_NODES by repeated subtract
	function automatic logic [NODE_W-1:0] node_mod(input logic [NODE_IN_W-1:0] v_in);
		logic [NODE_IN_W:0] v;
		v = {1'b0, v_in};
		for (int k = 0; k < 8; k++) begin
			if (int'(v) >= MAX_NODES) begin
				v = v - (NODE_IN_W+1)'(MAX_NODES);
			end
		end
		return NODE_W'(v);
	endfunction

	logic [CFG_W-1:0]     ncnt_q;
	logic [CNT_W-1:0]     nodes_act;
	logic [NODE_W-1:0]    pos_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [NODE_W-1:0]    scan_idx_q;
	logic                 cand_vld_s1;
	logic [NODE_W-1:0]    cand_idx_s1;
	logic                 found_q;
	logic [NODE_W-1:0]    best_idx_q;
	logic [COST_BITS-1:0] best_cost_q;
	logic [SUM_W-1:0]     sum_q;
	logic [ADDED_W-1:0]   added_q;

	logic [NODE_W-1:0]    pos_in;
	logic [MAX_NODES-1:0] vis_init;
	logic [MX_W-1:0]      mask_ext;
	logic                 tbl_we;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [NODE_W-1:0]    rd_col;
	logic [COST_BITS-1:0] rd_data;
	logic [COST_BITS-1:0] addend;
	logic [ADD_W-1:0]     sum_ext;
	logic [SUM_W-1:0]     sum_sat;
	logic                 better;

	// Clamp node count to 2..MAX_NODES
	always_comb begin
		if (CMP_W'(ncnt_q) < CMP_W'(2)) begin
			nodes_act = CNT_W'(2);
		end else if (CMP_W'(ncnt_q) > CMP_W'(MAX_NODES)) begin
			nodes_act = CNT_W'(MAX_NODES);
		end else begin
			nodes_act = CNT_W'(ncnt_q);
		end
	end

	// Starting visited set of a query
	assign pos_in   = node_mod(current_node);
	assign mask_ext = MX_W'(visited_mask);
	always_comb begin
		vis_init    = mask_ext[MAX_NODES-1:0];
		vis_init[0] = 1'b1;
		vis_init[pos_in] = 1'b1;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (CNT_W'(i) >= nodes_act) begin
				vis_init[i] = 1'b1;
			end
		end
	end

	// Table write and read addresses
	assign tbl_we = cmd.tbl_wr && (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);
	assign waddr  = ADDR_W'(ADDR_W'(from_node) * ADDR_W'(MAX_NODES) + ADDR_W'(to_node));
	assign rd_col = cmd.ret_rd ? '0 : scan_idx_q;
	assign raddr  = ADDR_W'(ADDR_W'(pos_q) * ADDR_W'(MAX_NODES) + ADDR_W'(rd_col));

	gtce_ram #(
		.WIDTH (COST_BITS),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr),
		.wdata (COST_BITS'(edge_cost)),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Saturating accumulator, shared by greedy step and return leg
	assign addend  = cmd.ret_add ? rd_data : best_cost_q;
	assign sum_ext = ADD_W'(sum_q) + ADD_W'(addend);
	assign sum_sat = (sum_ext > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_ext);

	assign better = !found_q || (rd_data < best_cost_q);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q      <= NODE_COUNT_RST;
			cand_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				ncnt_q <= cfg_wdata;
			end
			cand_vld_s1 <= cmd.scan_rd && !visited_q[scan_idx_q];
			if (cmd.load || cmd.take_best) begin
				found_q    <= 1'b0;
				scan_idx_q <= '0;
			end else begin
				if (cand_vld_s1) begin
					found_q <= 1'b1;
				end
				if (cmd.scan_rd) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
		end
	end

	// Walk state
	always_ff @(posedge clk) begin
		cand_idx_s1 <= scan_idx_q;
		if (cand_vld_s1 && better) begin
			best_idx_q  <= cand_idx_s1;
			best_cost_q <= rd_data;
		end
		if (cmd.load) begin
			pos_q     <= pos_in;
			visited_q <= vis_init;
			sum_q     <= '0;
			added_q   <= '0;
		end else if (cmd.take_best) begin
			pos_q                 <= best_idx_q;
			visited_q[best_idx_q] <= 1'b1;
			sum_q                 <= sum_sat;
			if (added_q != ADDED_MAX) begin
				added_q <= added_q + 1'b1;
			end
		end else if (cmd.ret_add) begin
			sum_q <= sum_sat;
		end
	end

	assign sts.scan_last = (CNT_W'(scan_idx_q) == nodes_act - 1'b1);
	assign sts.found     = found_q;
	assign sts.pos_zero  = (pos_q == '0);

	assign heuristic_cost = sum_q;
	assign nodes_added    = added_q;

`ifndef SYNTHESIS
	a_step_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_best |=> visited_q[pos_q])
		else $error("node stepped to is not marked visited");
	a_best_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !cmd.load && !cmd.take_best) |-> !visited_q[best_idx_q])
		else $error("best candidate already visited");
`endif

endmodule

`default_nettype wire
